/* rtl/u8vr_pkg.sv */
// shared types, constants and sequence tables for the utf-8 validate and repair block
package u8vr_pkg;

   localparam int SEQ_W       = 5;
   localparam int NUM_STATES  = 19;
   localparam int HELD_DEPTH  = 3;
   localparam int RES_DEPTH   = 5;
   localparam int CNT_W       = 3;

   // lead byte codes and continuation limits of the well-formed table
   localparam logic [7:0] ASCII_MAX   = 8'h7F;
   localparam logic [7:0] LEAD2_LO    = 8'hC2;
   localparam logic [7:0] LEAD2_HI    = 8'hDF;
   localparam logic [7:0] LEAD_E0     = 8'hE0;
   localparam logic [7:0] LEAD_ED     = 8'hED;
   localparam logic [7:0] LEAD_F0     = 8'hF0;
   localparam logic [7:0] LEAD_F4     = 8'hF4;
   localparam logic [7:0] LEAD4_LO    = 8'hF1;
   localparam logic [7:0] LEAD4_HI    = 8'hF3;
   localparam logic [7:0] CONT_LO     = 8'h80;
   localparam logic [7:0] CONT_HI     = 8'hBF;
   localparam logic [7:0] CONT_A0     = 8'hA0;
   localparam logic [7:0] CONT_9F     = 8'h9F;
   localparam logic [7:0] CONT_90     = 8'h90;
   localparam logic [7:0] CONT_8F     = 8'h8F;

   // sequence states
   localparam logic [SEQ_W-1:0] ST_IDLE    = 5'd0;
   localparam logic [SEQ_W-1:0] ST_C2_1    = 5'd1;
   localparam logic [SEQ_W-1:0] ST_E0_1    = 5'd2;
   localparam logic [SEQ_W-1:0] ST_E0_2    = 5'd3;
   localparam logic [SEQ_W-1:0] ST_E1_1    = 5'd4;
   localparam logic [SEQ_W-1:0] ST_E1_2    = 5'd5;
   localparam logic [SEQ_W-1:0] ST_ED_1    = 5'd6;
   localparam logic [SEQ_W-1:0] ST_ED_2    = 5'd7;
   localparam logic [SEQ_W-1:0] ST_EE_1    = 5'd8;
   localparam logic [SEQ_W-1:0] ST_EE_2    = 5'd9;
   localparam logic [SEQ_W-1:0] ST_F0_1    = 5'd10;
   localparam logic [SEQ_W-1:0] ST_F0_2    = 5'd11;
   localparam logic [SEQ_W-1:0] ST_F0_3    = 5'd12;
   localparam logic [SEQ_W-1:0] ST_F1_1    = 5'd13;
   localparam logic [SEQ_W-1:0] ST_F1_2    = 5'd14;
   localparam logic [SEQ_W-1:0] ST_F1_3    = 5'd15;
   localparam logic [SEQ_W-1:0] ST_F4_1    = 5'd16;
   localparam logic [SEQ_W-1:0] ST_F4_2    = 5'd17;
   localparam logic [SEQ_W-1:0] ST_F4_3    = 5'd18;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       string_summary;
      logic       well_formed;
      logic       last_of_run;
   } rsp_type;

   // control handed from the step logic to the state registers
   typedef struct packed {
      logic [SEQ_W-1:0] next_seq;
      logic             next_err;
      logic             held_we;
      logic [1:0]       held_idx;
      logic [CNT_W-1:0] res_count;
   } step_ctl_type;

   // lowest accepted byte in an open state
   function automatic logic [7:0] range_lo(input logic [SEQ_W-1:0] st);
      case (st)
         ST_IDLE: range_lo = 8'h00;
         ST_E0_1: range_lo = CONT_A0;
         ST_F0_1: range_lo = CONT_90;
         default: range_lo = CONT_LO;
      endcase
   endfunction

   // highest accepted byte in an open state
   function automatic logic [7:0] range_hi(input logic [SEQ_W-1:0] st);
      case (st)
         ST_IDLE: range_hi = ASCII_MAX;
         ST_ED_1: range_hi = CONT_9F;
         ST_F4_1: range_hi = CONT_8F;
         default: range_hi = CONT_HI;
      endcase
   endfunction

   // state after an accepted continuation byte
   function automatic logic [SEQ_W-1:0] cont_state(input logic [SEQ_W-1:0] st);
      case (st)
         ST_E0_1: cont_state = ST_E0_2;
         ST_E1_1: cont_state = ST_E1_2;
         ST_ED_1: cont_state = ST_ED_2;
         ST_EE_1: cont_state = ST_EE_2;
         ST_F0_1: cont_state = ST_F0_2;
         ST_F0_2: cont_state = ST_F0_3;
         ST_F1_1: cont_state = ST_F1_2;
         ST_F1_2: cont_state = ST_F1_3;
         ST_F4_1: cont_state = ST_F4_2;
         ST_F4_2: cont_state = ST_F4_3;
         default: cont_state = ST_IDLE;
      endcase
   endfunction

   // bytes already held in a state
   function automatic logic [1:0] held_count(input logic [SEQ_W-1:0] st);
      case (st) inside
         ST_IDLE:                                          held_count = 2'd0;
         ST_E0_2, ST_E1_2, ST_ED_2, ST_EE_2,
         ST_F0_2, ST_F1_2, ST_F4_2:                        held_count = 2'd2;
         ST_F0_3, ST_F1_3, ST_F4_3:                        held_count = 2'd3;
         default:                                          held_count = 2'd1;
      endcase
   endfunction

   // state entered by a lead byte, idle when the byte cannot start a sequence
   function automatic logic [SEQ_W-1:0] lead_state(input logic [7:0] b);
      case (b) inside
         LEAD_E0:              lead_state = ST_E0_1;
         LEAD_ED:              lead_state = ST_ED_1;
         LEAD_F0:              lead_state = ST_F0_1;
         LEAD_F4:              lead_state = ST_F4_1;
         [LEAD2_LO:LEAD2_HI]:  lead_state = ST_C2_1;
         [8'hE1:8'hEC]:        lead_state = ST_E1_1;
         [8'hEE:8'hEF]:        lead_state = ST_EE_1;
         [LEAD4_LO:LEAD4_HI]:  lead_state = ST_F1_1;
         default:              lead_state = ST_IDLE;
      endcase
   endfunction

endpackage

/* rtl/u8vr_step.sv */
// per-byte step logic: sequence check, held byte update and result list
module u8vr_step
   import u8vr_pkg::*;
(
   input  logic [SEQ_W-1:0]                 seq_state,
   input  logic                             err_seen,
   input  logic [HELD_DEPTH-1:0][7:0]       held,
   input  logic                             repair,
   input  req_type                          item,
   output step_ctl_type                     ctl,
   output rsp_type [RES_DEPTH-1:0]          res
);

   logic [SEQ_W-1:0] st;
   logic [SEQ_W-1:0] nx;
   logic [1:0]       h;
   logic [7:0]       b;
   logic             done;
   logic             err;
   logic [CNT_W-1:0] n;

   always_comb begin
      b    = item.data_byte;
      st   = (seq_state >= SEQ_W'(NUM_STATES)) ? ST_IDLE : seq_state;
      h    = held_count(st);
      nx   = cont_state(st);
      done = 1'b0;
      err  = err_seen;
      n    = '0;
      res  = '0;
      ctl  = '0;

      // continuation of an open sequence
      if (st != ST_IDLE) begin
         if (b >= range_lo(st) && b <= range_hi(st)) begin
            if (nx == ST_IDLE) begin
               if (repair) begin
                  for (int i = 0; i < HELD_DEPTH; i++) begin
                     if (2'(i) < h) begin
                        res[i].out_byte     = held[i];
                        res[i].byte_present = 1'b1;
                     end
                  end
                  res[{1'b0, h}].out_byte     = b;
                  res[{1'b0, h}].byte_present = 1'b1;
                  n = {1'b0, h} + 3'd1;
               end
            end else if (h < 2'd3) begin
               ctl.held_we  = 1'b1;
               ctl.held_idx = h;
            end
            st   = nx;
            done = 1'b1;
         end else begin
            err = 1'b1;
            st  = ST_IDLE;
         end
      end

      // sequence start, also for a rejected continuation byte
      if (!done) begin
         if (b <= ASCII_MAX) begin
            if (repair) begin
               res[0].out_byte     = b;
               res[0].byte_present = 1'b1;
               n = 3'd1;
            end
         end else if (lead_state(b) != ST_IDLE) begin
            ctl.held_we  = 1'b1;
            ctl.held_idx = 2'd0;
            st = lead_state(b);
         end else begin
            err = 1'b1;
         end
      end

      // end of string summary
      if (item.end_of_string) begin
         if (st != ST_IDLE)
            err = 1'b1;
         st = ST_IDLE;
         res[n].string_summary = 1'b1;
         res[n].well_formed    = !err;
         n   = n + 3'd1;
         err = 1'b0;
      end

      if (n != '0)
         res[n - 3'd1].last_of_run = 1'b1;

      ctl.next_seq  = st;
      ctl.next_err  = err;
      ctl.res_count = n;
   end

endmodule

/* rtl/utf8_validate_and_repair_top.sv */
// top level of the utf-8 validate and repair block: state, result buffer and handshakes
// Checks one string byte per req transaction against the well-formed utf-8 byte ranges and,
// with repair_enable set, passes on ascii bytes at once and multibyte sequences whole when
// their last byte arrives; bad bytes and unfinished sequences are dropped, and the last byte
// of a string also yields a summary transaction with well_formed. A byte is taken every
// cycle as long as each byte gives at most one result and rsp_stall stays low; a byte that
// completes a sequence or ends a string gives n results (up to five) that leave one per
// cycle while rsp_stall is low from the five-entry result buffer, and the req side is held
// off until the last of them is taken. Results are registered and appear on rsp in the cycle
// after their byte is taken. repair_enable is written on the csr channel, which is always ready.
module utf8_validate_and_repair_top
   import u8vr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic                       repair_ff;
   logic [SEQ_W-1:0]           seq_ff, seq_in;
   logic                       err_ff, err_in;
   logic [HELD_DEPTH-1:0][7:0] held_ff;
   rsp_type [RES_DEPTH-1:0]    buf_ff, buf_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   rsp_type [RES_DEPTH-1:0]    step_res;
   step_ctl_type               step_ctl;
   logic                       req_take;
   logic                       rsp_take;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         repair_ff <= 1'b1;
      else if (csr_valid && csr_ready)
         repair_ff <= csr_data;
   end

   // handshakes
   assign rsp_valid   = (cnt_ff != '0);
   assign rsp_payload = buf_ff[0];
   assign rsp_take    = rsp_valid && !rsp_stall;
   assign req_stall   = !((cnt_ff == '0) || (cnt_ff == 3'd1 && rsp_take));
   assign req_take    = req_valid && !req_stall;

   u8vr_step u_step (
      .seq_state (seq_ff),
      .err_seen  (err_ff),
      .held      (held_ff),
      .repair    (repair_ff),
      .item      (req_payload),
      .ctl       (step_ctl),
      .res       (step_res)
   );

   // sequence state and error flag
   always_comb begin
      seq_in = seq_ff;
      err_in = err_ff;
      if (req_take) begin
         seq_in = step_ctl.next_seq;
         err_in = step_ctl.next_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= ST_IDLE;
         err_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         err_ff <= err_in;
      end
   end

   // held lead and continuation bytes
   always_ff @(posedge clock) begin
      if (req_take && step_ctl.held_we)
         held_ff[step_ctl.held_idx] <= req_payload.data_byte;
   end

   // result buffer: load on accept, shift on each taken transaction
   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (req_take) begin
         buf_in = step_res;
         cnt_in = step_ctl.res_count;
      end else if (rsp_take) begin
         for (int i = 0; i < RES_DEPTH - 1; i++)
            buf_in[i] = buf_ff[i + 1];
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= '0;
      else
         cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   // the result count never exceeds the buffer depth, as the buffer holds one byte's results at most
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CNT_W'(RES_DEPTH))
      else $error("result buffer count out of range");

   // a new byte is only taken when the buffer is empty or its last result drains in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |-> (cnt_ff == '0 || (cnt_ff == 3'd1 && rsp_take)))
      else $error("byte accepted over pending results");

   // a summary closes the run of its byte and carries no byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.string_summary) |->
         (rsp_payload.last_of_run && !rsp_payload.byte_present))
      else $error("malformed summary transaction");

   // end of string always leaves no sequence open and no error pending
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_payload.end_of_string) |=> (seq_ff == ST_IDLE && !err_ff))
      else $error("state not cleared at end of string");

endmodule
